// ----- rtl/zoh_pkg.sv -----
package zoh_pkg;

    // Field widths and filter shape
    localparam int NUM_CHANNELS = 2;
    localparam int TAPS         = 129;
    localparam int FACTOR       = 4;
    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 18;
    localparam int CHAN_BITS    = 1;
    localparam int PHASE_BITS   = 2;
    localparam int CENTER_TAP   = (TAPS - 1) / 2;

    // Kaiser lowpass design constants: cutoff 11/50, (beta/2)^2 = 16
    localparam int          CUT_NUM         = 11;
    localparam int          CUT_DEN         = 50;
    localparam int          BETA_SQ_QUARTER = 16;
    localparam logic [63:0] PI_Q30          = 64'd3373259426;

    // Derived widths
    localparam int TAP_BITS    = $clog2(TAPS);
    localparam int FILL_BITS   = $clog2(TAPS + 1);
    localparam int PH_CNT_BITS = $clog2(FACTOR);
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + $clog2(TAPS) + 1;
    localparam int SH_BITS     = ACC_BITS - COEF_BITS + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Rounding offset preloaded into the accumulator
    localparam logic signed [ACC_BITS-1:0] ACC_INIT = ACC_BITS'(1) << (COEF_BITS - 2);

    // Saturation bounds on the shifted accumulator
    localparam logic signed [SH_BITS-1:0] SAT_HI =
        {{(SH_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SH_BITS-1:0] SAT_LO = ~SAT_HI;

    typedef logic [63:0] u64_t;
    typedef logic signed [63:0] s64_t;
    typedef logic [TAPS-1:0][COEF_BITS-1:0] coef_rom_t;

    // One queued base-rate beat
    typedef struct packed {
        logic [CHAN_BITS-1:0]          ch;
        logic signed [SAMPLE_BITS-1:0] sample;
    } item_t;

    // Restoring shift-subtract quotient, used only while building the table
    function automatic u64_t udiv64(input u64_t num, input u64_t dvs);
        u64_t quo;
        u64_t rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= dvs)
            begin
                rem    = rem - dvs;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Remainder from the same quotient
    function automatic u64_t urem64(input u64_t num, input u64_t dvs);
        return num - udiv64(num, dvs) * dvs;
    endfunction

    // Modified Bessel I0 as a Q32 series, argument (x/2)^2 in Q16
    function automatic u64_t bessel_i0_q32(input u64_t x2q16);
        u64_t sum;
        u64_t term;
        u64_t k;
        sum  = u64_t'(1) << 32;
        term = u64_t'(1) << 32;
        for (k = u64_t'(1); k <= u64_t'(40); k++)
        begin
            term = udiv64((term * x2q16) >> 16, k * k);
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Taylor sine in Q30 on an angle of at most pi/2
    function automatic u64_t sine_q30(input u64_t a);
        u64_t a2;
        u64_t term;
        u64_t sum;
        u64_t j;
        a2   = (a * a) >> 30;
        term = a;
        sum  = a;
        for (j = u64_t'(1); j <= u64_t'(10); j++)
        begin
            term = udiv64((term * a2) >> 30, (2 * j) * (2 * j + 1));
            if (j[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    // Windowed-sinc coefficient table, normalized to unity DC gain
    function automatic coef_rom_t build_rom();
        coef_rom_t rom;
        u64_t      mag [TAPS];
        logic      neg [TAPS];
        u64_t      m;
        u64_t      center;
        u64_t      den;
        s64_t      total;
        u64_t      x2;
        u64_t      w;
        u64_t      ak;
        u64_t      h;
        u64_t      t;
        u64_t      s;
        u64_t      c;
        s64_t      v;
        logic      ng;
        m      = u64_t'(TAPS - 1);
        center = u64_t'(CENTER_TAP);
        den    = bessel_i0_q32(u64_t'(BETA_SQ_QUARTER) << 16) >> 10;
        total  = '0;
        for (int n = 0; n < TAPS; n++)
        begin
            x2 = udiv64((u64_t'(4 * BETA_SQ_QUARTER) * u64_t'(n) * (m - u64_t'(n))) << 16,
                        m * m);
            w  = udiv64(bessel_i0_q32(x2) << 20, den);
            ak = (u64_t'(n) >= center) ? u64_t'(n) - center : center - u64_t'(n);
            ng = 1'b0;
            if (ak == 0)
            begin
                h = udiv64(u64_t'(2 * CUT_NUM) << 30, u64_t'(CUT_DEN));
            end
            else
            begin
                t = 2 * urem64(u64_t'(CUT_NUM) * ak, u64_t'(CUT_DEN));
                if (t >= u64_t'(CUT_DEN))
                begin
                    t  = t - u64_t'(CUT_DEN);
                    ng = 1'b1;
                end
                if (2 * t > u64_t'(CUT_DEN))
                    t = u64_t'(CUT_DEN) - t;
                h = udiv64(sine_q30(udiv64(PI_Q30 * t, u64_t'(CUT_DEN))) << 30,
                           PI_Q30 * ak);
            end
            mag[n] = (h * w) >> 30;
            neg[n] = ng;
            total  = ng ? total - s64_t'(mag[n]) : total + s64_t'(mag[n]);
        end
        for (int n = 0; n < TAPS; n++)
        begin
            if (total > 0)
            begin
                s = u64_t'(total);
                c = udiv64((mag[n] << (COEF_BITS - 1)) + (s >> 1), s);
            end
            else
            begin
                c = mag[n] >> (30 - (COEF_BITS - 1));
            end
            if (neg[n])
            begin
                if (c > (u64_t'(1) << (COEF_BITS - 1)))
                    c = u64_t'(1) << (COEF_BITS - 1);
                v = -s64_t'(c);
            end
            else
            begin
                if (c > (u64_t'(1) << (COEF_BITS - 1)) - 1)
                    c = (u64_t'(1) << (COEF_BITS - 1)) - 1;
                v = s64_t'(c);
            end
            rom[n] = v[COEF_BITS-1:0];
        end
        return rom;
    endfunction

    localparam coef_rom_t COEF_ROM = build_rom();

endpackage

// ----- rtl/zoh_fir_interpolator_x4.sv -----
// One shared multiply-accumulate unit sweeps all 129 taps once per oversampled output and
// finishes all four outputs of a beat before it starts the next; result_stall can hold it.
// Results for a beat leave in phase order, one per sweep.
// A two-entry input queue takes new beats while the filter works; one output register.
// Reset (rst_n, async, active low) empties the queue and output and zeroes every delay
// line via per-channel fill counts; no clearing pass is needed.
module zoh_fir_interpolator_x4
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic [zoh_pkg::CHAN_BITS-1:0]          channel_in,
    input  logic signed [zoh_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [zoh_pkg::CHAN_BITS-1:0]          channel_out,
    output logic [zoh_pkg::PHASE_BITS-1:0]         phase,
    output logic signed [zoh_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                   last
);

    logic           q_valid;
    logic           q_pop;
    zoh_pkg::item_t q_item;

    // Accept and queue base-rate beats
    zoh_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .channel_in (channel_in),
        .sample_in  (sample_in),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Filter each held copy and emit the results
    zoh_mac u_mac
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .channel_out  (channel_out),
        .phase        (phase),
        .sample_out   (sample_out),
        .last         (last)
    );

endmodule

// ----- rtl/zoh_front.sv -----
module zoh_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [zoh_pkg::CHAN_BITS-1:0]        channel_in,
    input  logic signed [zoh_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                 q_valid,
    output zoh_pkg::item_t                       q_item,
    input  logic                                 q_pop
);

    zoh_pkg::item_t                    ent_reg [zoh_pkg::QUEUE_DEPTH];
    logic [zoh_pkg::QPTR_BITS-1:0]     wr_ptr_reg;
    logic [zoh_pkg::QPTR_BITS-1:0]     wr_ptr_next;
    logic [zoh_pkg::QPTR_BITS-1:0]     rd_ptr_reg;
    logic [zoh_pkg::QPTR_BITS-1:0]     rd_ptr_next;
    logic [zoh_pkg::QCNT_BITS-1:0]     cnt_reg;
    logic [zoh_pkg::QCNT_BITS-1:0]     cnt_next;
    logic                              chan_ok;
    logic                              push;
    logic                              pop;

    // Classify: drop beats for channels that do not exist
    assign chan_ok    = int'(channel_in) < zoh_pkg::NUM_CHANNELS;
    assign item_stall = (cnt_reg == zoh_pkg::QCNT_BITS'(zoh_pkg::QUEUE_DEPTH));
    assign push       = item_valid && !item_stall && chan_ok;
    assign pop        = q_pop && (cnt_reg != '0);

    assign q_valid = (cnt_reg != '0);
    assign q_item  = ent_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == zoh_pkg::QPTR_BITS'(zoh_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == zoh_pkg::QPTR_BITS'(zoh_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg].ch     <= channel_in;
            ent_reg[wr_ptr_reg].sample <= sample_in;
        end
    end

endmodule

// ----- rtl/zoh_mac.sv -----
module zoh_mac
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  zoh_pkg::item_t                         q_item,
    output logic                                   q_pop,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [zoh_pkg::CHAN_BITS-1:0]          channel_out,
    output logic [zoh_pkg::PHASE_BITS-1:0]         phase,
    output logic signed [zoh_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                   last
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PUSH  = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } mac_state_t;

    mac_state_t                               state_reg;
    mac_state_t                               state_next;
    logic [zoh_pkg::CHAN_BITS-1:0]            ch_reg;
    logic [zoh_pkg::CHAN_BITS-1:0]            ch_next;
    logic signed [zoh_pkg::SAMPLE_BITS-1:0]   smp_reg;
    logic signed [zoh_pkg::SAMPLE_BITS-1:0]   smp_next;
    logic [zoh_pkg::PH_CNT_BITS-1:0]          ph_reg;
    logic [zoh_pkg::PH_CNT_BITS-1:0]          ph_next;
    logic [zoh_pkg::TAP_BITS-1:0]             tap_reg;
    logic [zoh_pkg::TAP_BITS-1:0]             tap_next;
    logic [zoh_pkg::TAP_BITS-1:0]             rptr_reg;
    logic [zoh_pkg::TAP_BITS-1:0]             rptr_next;
    logic signed [zoh_pkg::ACC_BITS-1:0]      acc_reg;
    logic signed [zoh_pkg::ACC_BITS-1:0]      acc_next;
    logic [zoh_pkg::TAP_BITS-1:0]             wp_reg [zoh_pkg::NUM_CHANNELS];
    logic [zoh_pkg::FILL_BITS-1:0]            fill_reg [zoh_pkg::NUM_CHANNELS];

    logic                                     s1_valid_reg;
    logic                                     s1_live_reg;
    logic signed [zoh_pkg::COEF_BITS-1:0]     s1_coef_reg;
    logic signed [zoh_pkg::SAMPLE_BITS-1:0]   rd_data_reg;
    logic                                     s2_valid_reg;
    logic signed [zoh_pkg::PROD_BITS-1:0]     prod_reg;
    logic signed [zoh_pkg::SAMPLE_BITS-1:0]   mac_op;

    logic                                     out_valid_reg;
    logic [zoh_pkg::CHAN_BITS-1:0]            out_ch_reg;
    logic [zoh_pkg::PHASE_BITS-1:0]           out_ph_reg;
    logic signed [zoh_pkg::SAMPLE_BITS-1:0]   out_smp_reg;
    logic                                     out_last_reg;

    logic signed [zoh_pkg::SAMPLE_BITS-1:0]   dmem [zoh_pkg::NUM_CHANNELS][zoh_pkg::TAPS];

    logic [zoh_pkg::TAP_BITS-1:0]             wp_cur;
    logic [zoh_pkg::TAP_BITS-1:0]             wp_new;
    logic [zoh_pkg::FILL_BITS-1:0]            fill_cur;
    logic [zoh_pkg::FILL_BITS-1:0]            fill_inc;
    logic                                     mem_we;
    logic                                     mem_re;
    logic                                     is_last;
    logic                                     out_free;
    logic                                     out_load;
    logic signed [zoh_pkg::SH_BITS-1:0]       acc_sh;
    logic signed [zoh_pkg::SAMPLE_BITS-1:0]   sat_val;

    // Circular delay line per channel: newest entry at the write pointer
    assign wp_cur   = wp_reg[ch_reg];
    assign wp_new   = (wp_cur == '0) ? zoh_pkg::TAP_BITS'(zoh_pkg::TAPS - 1) : wp_cur - 1'b1;
    assign fill_cur = fill_reg[ch_reg];
    assign fill_inc = (fill_cur == zoh_pkg::FILL_BITS'(zoh_pkg::TAPS))
                      ? fill_cur : fill_cur + 1'b1;
    assign is_last  = (ph_reg == zoh_pkg::PH_CNT_BITS'(zoh_pkg::FACTOR - 1));
    assign out_free = !out_valid_reg || !result_stall;

    // Round and saturate the finished sum
    assign acc_sh  = acc_reg[zoh_pkg::ACC_BITS-1:zoh_pkg::COEF_BITS-1];
    assign sat_val = (acc_sh > zoh_pkg::SAT_HI) ? zoh_pkg::SAT_HI[zoh_pkg::SAMPLE_BITS-1:0] :
                     (acc_sh < zoh_pkg::SAT_LO) ? zoh_pkg::SAT_LO[zoh_pkg::SAMPLE_BITS-1:0] :
                     acc_sh[zoh_pkg::SAMPLE_BITS-1:0];

    // Sequencer: push one copy, sweep all taps, drain, emit
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        smp_next   = smp_reg;
        ph_next    = ph_reg;
        tap_next   = tap_reg;
        rptr_next  = rptr_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    ch_next    = q_item.ch;
                    smp_next   = q_item.sample;
                    ph_next    = '0;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                mem_we     = 1'b1;
                rptr_next  = wp_new;
                tap_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                mem_re    = 1'b1;
                rptr_next = (rptr_reg == zoh_pkg::TAP_BITS'(zoh_pkg::TAPS - 1))
                            ? '0 : rptr_reg + 1'b1;
                tap_next  = tap_reg + 1'b1;
                if (tap_reg == zoh_pkg::TAP_BITS'(zoh_pkg::TAPS - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ph_next    = ph_reg + 1'b1;
                        state_next = ST_PUSH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Accumulate: preload the rounding offset on push, add products as they land
    always_comb
    begin
        acc_next = acc_reg;
        if (mem_we)
            acc_next = zoh_pkg::ACC_INIT;
        else if (s2_valid_reg)
            acc_next = acc_reg + zoh_pkg::ACC_BITS'(prod_reg);
    end

    // Zero taps that have not been filled since reset
    assign mac_op = s1_live_reg ? rd_data_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < zoh_pkg::NUM_CHANNELS; c++)
            begin
                wp_reg[c]   <= '0;
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= mem_re;
            s2_valid_reg <= s1_valid_reg;
            if (mem_we)
            begin
                wp_reg[ch_reg]   <= wp_new;
                fill_reg[ch_reg] <= fill_inc;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        ch_reg      <= ch_next;
        smp_reg     <= smp_next;
        ph_reg      <= ph_next;
        tap_reg     <= tap_next;
        rptr_reg    <= rptr_next;
        acc_reg     <= acc_next;
        s1_coef_reg <= zoh_pkg::COEF_ROM[tap_reg];
        s1_live_reg <= (zoh_pkg::FILL_BITS'(tap_reg) < fill_cur);
        prod_reg    <= s1_coef_reg * mac_op;
        if (out_load)
        begin
            out_ch_reg   <= ch_reg;
            out_ph_reg   <= zoh_pkg::PHASE_BITS'(ph_reg);
            out_smp_reg  <= sat_val;
            out_last_reg <= is_last;
        end
    end

    // Delay memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            dmem[ch_reg][wp_new] <= smp_reg;
        if (mem_re)
            rd_data_reg <= dmem[ch_reg][rptr_reg];
    end

    assign result_valid = out_valid_reg;
    assign channel_out  = out_ch_reg;
    assign phase        = out_ph_reg;
    assign sample_out   = out_smp_reg;
    assign last         = out_last_reg;

endmodule
